@@ src/vcws_pkg.sv @@
// Package for the viewport chunk window splitter.
// Holds the payload, configuration and job types, the slot and register codes
// and the reset values. No dependencies.
`default_nettype none

package vcws_pkg;

  localparam int MAX_CHUNK_DIM  = 256;
  localparam int MAX_WINDOW_DIM = 63;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] TILE_SIZE_RST   = 8'd16;
  localparam logic [5:0] WINDOW_COLS_RST = 6'd10;
  localparam logic [5:0] WINDOW_ROWS_RST = 6'd9;
  localparam logic [5:0] PLAYER_COL_RST  = 6'd4;
  localparam logic [5:0] PLAYER_ROW_RST  = 6'd4;
  localparam logic [8:0] CHUNK_COLS_RST  = 9'd16;
  localparam logic [8:0] CHUNK_ROWS_RST  = 9'd16;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_INC  = 2'sb01;
  localparam logic signed [1:0] STEP_DEC  = 2'sb11;

  typedef enum logic [2:0] {
    REG_TILE_SIZE   = 3'd0,
    REG_WINDOW_COLS = 3'd1,
    REG_WINDOW_ROWS = 3'd2,
    REG_PLAYER_COL  = 3'd3,
    REG_PLAYER_ROW  = 3'd4,
    REG_CHUNK_COLS  = 3'd5,
    REG_CHUNK_ROWS  = 3'd6
  } vcws_reg_t;

  typedef enum logic [1:0] {
    SLOT_CUR  = 2'd0,
    SLOT_HORZ = 2'd1,
    SLOT_VERT = 2'd2,
    SLOT_DIAG = 2'd3
  } vcws_slot_t;

  typedef struct packed {
    logic        [7:0]  rel_col;
    logic        [7:0]  rel_row;
    logic signed [15:0] cur_chunk_x;
    logic signed [15:0] cur_chunk_y;
    logic        [1:0]  focus_col;
    logic        [1:0]  focus_row;
    logic        [8:0]  neighbour_mask;
  } vcws_in_t;

  typedef struct packed {
    logic        [1:0]  slot;
    logic               present;
    logic signed [15:0] x_px;
    logic signed [15:0] y_px;
    logic        [8:0]  span_cols;
    logic        [8:0]  span_rows;
    logic        [7:0]  first_col;
    logic        [7:0]  first_row;
    logic signed [15:0] out_chunk_x;
    logic signed [15:0] out_chunk_y;
    logic               last;
  } vcws_out_t;

  typedef struct packed {
    logic [7:0] tile_size;
    logic [5:0] window_cols;
    logic [5:0] window_rows;
    logic [5:0] player_col;
    logic [5:0] player_row;
    logic [8:0] chunk_cols;
    logic [8:0] chunk_rows;
  } vcws_cfg_t;

  typedef struct packed {
    logic signed [15:0] org0;
    logic signed [15:0] org1;
    logic        [8:0]  span0;
    logic        [8:0]  span1;
    logic        [7:0]  first0;
    logic        [7:0]  first1;
    logic signed [1:0]  step;
  } vcws_axis_t;

  typedef struct packed {
    vcws_axis_t         h;
    vcws_axis_t         v;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               p1;
    logic               p2;
    logic               p3;
  } vcws_job_t;

endpackage

`default_nettype wire

@@ src/vcws_front.sv @@
// Front end: accepts requests and splits both axes in two register stages.
// Depends on vcws_pkg.
`default_nettype none

module vcws_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vcws_pkg::vcws_cfg_t cfg,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire vcws_pkg::vcws_in_t  req,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output vcws_pkg::vcws_job_t    push_job
);
  import vcws_pkg::*;

  typedef struct packed {
    logic signed [1:0]  step;
    logic signed [11:0] span0;
    logic signed [11:0] span1;
    logic signed [11:0] first0;
    logic signed [11:0] first1;
    logic        [6:0]  mul_op;
  } vcws_pre_t;

  typedef struct packed {
    vcws_pre_t          h;
    vcws_pre_t          v;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               p1;
    logic               p2;
    logic               p3;
  } vcws_stage_t;

  function automatic vcws_pre_t axis_pre(input logic [7:0] rel, input logic [5:0] player,
                                         input logic [5:0] win, input logic [8:0] csz);
    vcws_pre_t          r;
    logic signed [11:0] lead;
    logic signed [11:0] room;
    logic signed [11:0] inv;
    logic signed [11:0] u;
    logic signed [11:0] v;
    logic signed [11:0] s0;
    lead = $signed({4'd0, rel}) - $signed({6'd0, player}) - 12'sd1;
    room = $signed({3'd0, csz}) - $signed({4'd0, rel}) - 12'sd1;
    inv  = $signed({6'd0, win}) - $signed({6'd0, player}) - 12'sd1;
    s0   = $signed({6'd0, win}) + 12'sd2;
    u    = 12'sd0 - lead;
    v    = 12'sd0;
    r.step   = STEP_NONE;
    r.span1  = 12'sd0;
    r.first0 = 12'sd0;
    r.first1 = 12'sd0;
    r.mul_op = 7'd0;
    if (lead < 12'sd0) begin
      s0       = s0 - u;
      r.span1  = u;
      r.first1 = $signed({3'd0, csz}) - u;
      r.step   = STEP_DEC;
      r.mul_op = 7'(u - 12'sd1);
    end else begin
      r.first0 = lead;
      if (inv < 12'sd0) begin
        inv = 12'sd0;
      end
      if (room >= 12'sd0 && room < inv + 12'sd1) begin
        v        = inv + 12'sd1 - room;
        s0       = s0 - v;
        r.span1  = v;
        r.step   = STEP_INC;
        r.mul_op = 7'(s0 - 12'sd1);
      end
    end
    r.span0 = s0;
    return r;
  endfunction

  function automatic logic cell_exists(input logic [8:0] mask, input logic [1:0] fc,
                                       input logic [1:0] fr, input logic signed [1:0] dc,
                                       input logic signed [1:0] dr);
    logic signed [3:0] c;
    logic signed [3:0] r;
    logic        [3:0] idx;
    c   = $signed({2'd0, fc}) + $signed({{2{dc[1]}}, dc});
    r   = $signed({2'd0, fr}) + $signed({{2{dr[1]}}, dr});
    idx = {2'd0, c[1:0]} * 4'd3 + {2'd0, r[1:0]};
    if (c < 4'sd0 || c > 4'sd2 || r < 4'sd0 || r > 4'sd2) begin
      return 1'b0;
    end
    return mask[idx];
  endfunction

  function automatic logic [8:0] clamp_span(input logic signed [11:0] s, input logic [8:0] csz);
    logic signed [11:0] c;
    logic signed [11:0] r;
    c = $signed({3'd0, csz});
    r = s;
    if (r > c) begin
      r = c;
    end
    if (r < 12'sd0) begin
      r = 12'sd0;
    end
    return r[8:0];
  endfunction

  function automatic logic [7:0] clamp_first(input logic signed [11:0] f);
    if (f < 12'sd0) begin
      return 8'd0;
    end
    if (f > 12'sd255) begin
      return 8'd255;
    end
    return f[7:0];
  endfunction

  function automatic vcws_axis_t axis_finish(input vcws_pre_t p, input logic [7:0] t,
                                             input logic [8:0] csz);
    vcws_axis_t         a;
    logic        [14:0] prod;
    logic signed [15:0] pos;
    logic signed [15:0] neg_t;
    prod  = {7'd0, t} * {8'd0, p.mul_op};
    pos   = $signed({1'b0, prod});
    neg_t = 16'sd0 - $signed({8'd0, t});
    a.org0 = (p.step == STEP_DEC) ? pos : neg_t;
    priority if (p.step == STEP_DEC) begin
      a.org1 = neg_t;
    end else if (p.step == STEP_INC) begin
      a.org1 = pos;
    end else begin
      a.org1 = 16'sd0;
    end
    a.span0  = clamp_span(p.span0, csz);
    a.span1  = clamp_span(p.span1, csz);
    a.first0 = clamp_first(p.first0);
    a.first1 = clamp_first(p.first1);
    a.step   = p.step;
    return a;
  endfunction

  logic        s1_valid;
  logic        s2_valid;
  vcws_stage_t s1;
  vcws_stage_t s1_next;
  vcws_job_t   s2;
  logic        en1;
  logic        en2;

  assign en2        = !s2_valid || push_ready;
  assign en1        = !s1_valid || en2;
  assign req_stall  = !en1;
  assign push_valid = s2_valid;
  assign push_job   = s2;

  always_comb begin
    s1_next.h  = axis_pre(req.rel_col, cfg.player_col, cfg.window_cols, cfg.chunk_cols);
    s1_next.v  = axis_pre(req.rel_row, cfg.player_row, cfg.window_rows, cfg.chunk_rows);
    s1_next.cx = req.cur_chunk_x;
    s1_next.cy = req.cur_chunk_y;
    s1_next.p1 = (s1_next.h.step != STEP_NONE) &&
                 cell_exists(req.neighbour_mask, req.focus_col, req.focus_row,
                             s1_next.h.step, STEP_NONE);
    s1_next.p2 = (s1_next.v.step != STEP_NONE) &&
                 cell_exists(req.neighbour_mask, req.focus_col, req.focus_row,
                             STEP_NONE, s1_next.v.step);
    s1_next.p3 = s1_next.p1 && s1_next.p2 &&
                 cell_exists(req.neighbour_mask, req.focus_col, req.focus_row,
                             s1_next.h.step, s1_next.v.step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= req_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= s1_next;
    end
    if (en2) begin
      s2.h  <= axis_finish(s1.h, cfg.tile_size, cfg.chunk_cols);
      s2.v  <= axis_finish(s1.v, cfg.tile_size, cfg.chunk_rows);
      s2.cx <= s1.cx;
      s2.cy <= s1.cy;
      s2.p1 <= s1.p1;
      s2.p2 <= s1.p2;
      s2.p3 <= s1.p3;
    end
  end

endmodule

`default_nettype wire

@@ src/vcws_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on vcws_pkg.
`default_nettype none

module vcws_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire vcws_pkg::vcws_job_t push_job,
  output logic                     head_valid,
  input  wire logic                pop,
  output vcws_pkg::vcws_job_t      head_job
);
  import vcws_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  vcws_job_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             take;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !take) begin
        count <= count + CNT_W'(1);
      end else if (take && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ src/vcws_back.sv @@
// Back end: walks the four slots of the head job and drives the output register.
// Depends on vcws_pkg.
`default_nettype none

module vcws_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire vcws_pkg::vcws_job_t head_job,
  output logic                     pop,
  output logic                     rect_valid,
  input  wire logic                rect_stall,
  output vcws_pkg::vcws_out_t      rect
);
  import vcws_pkg::*;

  vcws_slot_t         slot;
  vcws_slot_t         slot_next;
  vcws_out_t          beat;
  logic               load;
  logic signed [15:0] nx;
  logic signed [15:0] ny;

  assign load = head_valid && (!rect_valid || !rect_stall);
  assign pop  = load && (slot == SLOT_DIAG);
  assign nx   = head_job.cx + {{14{head_job.h.step[1]}}, head_job.h.step};
  assign ny   = head_job.cy + {{14{head_job.v.step[1]}}, head_job.v.step};

  always_comb begin
    slot_next = vcws_slot_t'(2'(slot + 2'd1));
    beat      = '0;
    unique case (slot)
      SLOT_CUR: begin
        beat.present     = 1'b1;
        beat.x_px        = head_job.h.org0;
        beat.y_px        = head_job.v.org0;
        beat.span_cols   = head_job.h.span0;
        beat.span_rows   = head_job.v.span0;
        beat.first_col   = head_job.h.first0;
        beat.first_row   = head_job.v.first0;
        beat.out_chunk_x = head_job.cx;
        beat.out_chunk_y = head_job.cy;
      end
      SLOT_HORZ: begin
        beat.present     = head_job.p1;
        beat.x_px        = head_job.h.org1;
        beat.y_px        = head_job.v.org0;
        beat.span_cols   = head_job.h.span1;
        beat.span_rows   = head_job.v.span0;
        beat.first_col   = head_job.h.first1;
        beat.first_row   = head_job.v.first0;
        beat.out_chunk_x = nx;
        beat.out_chunk_y = head_job.cy;
      end
      SLOT_VERT: begin
        beat.present     = head_job.p2;
        beat.x_px        = head_job.h.org0;
        beat.y_px        = head_job.v.org1;
        beat.span_cols   = head_job.h.span0;
        beat.span_rows   = head_job.v.span1;
        beat.first_col   = head_job.h.first0;
        beat.first_row   = head_job.v.first1;
        beat.out_chunk_x = head_job.cx;
        beat.out_chunk_y = ny;
      end
      SLOT_DIAG: begin
        beat.present     = head_job.p3;
        beat.x_px        = head_job.h.org1;
        beat.y_px        = head_job.v.org1;
        beat.span_cols   = head_job.h.span1;
        beat.span_rows   = head_job.v.span1;
        beat.first_col   = head_job.h.first1;
        beat.first_row   = head_job.v.first1;
        beat.out_chunk_x = nx;
        beat.out_chunk_y = ny;
      end
      default: begin
        beat.present = 1'b0;
      end
    endcase
    if (!beat.present) begin
      beat = '0;
    end
    beat.slot = slot;
    beat.last = (slot == SLOT_DIAG);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= SLOT_CUR;
      rect_valid <= 1'b0;
    end else begin
      if (load) begin
        slot       <= slot_next;
        rect_valid <= 1'b1;
      end else if (!rect_stall) begin
        rect_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rect <= beat;
    end
  end

endmodule

`default_nettype wire

@@ src/viewport_chunk_window_split.sv @@
// The first beat of a request passes the front-end registers s1 and s2, a queue entry
// and the output register rect. Each request gives four beats, one per slot in order,
// and the back end pops a job only at its last slot, so the next job waits for that walk.
// A request is taken each cycle while the two-entry job queue has room.
// Reset loads the register defaults and empties the pipeline, queue and output.
`default_nettype none

module viewport_chunk_window_split (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [8:0]          cfg_data,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire vcws_pkg::vcws_in_t  req,
  output logic                     rect_valid,
  input  wire logic                rect_stall,
  output vcws_pkg::vcws_out_t      rect
);
  import vcws_pkg::*;

  vcws_cfg_t  cfg;
  logic       push_valid;
  logic       push_ready;
  vcws_job_t  push_job;
  logic       head_valid;
  logic       pop;
  vcws_job_t  head_job;
  logic [5:0] win_sat;
  logic [8:0] chunk_sat;

  assign win_sat   = (32'(cfg_data[5:0]) > MAX_WINDOW_DIM) ? 6'(MAX_WINDOW_DIM) : cfg_data[5:0];
  assign chunk_sat = (32'(cfg_data) > MAX_CHUNK_DIM) ? 9'(MAX_CHUNK_DIM) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_size   <= TILE_SIZE_RST;
      cfg.window_cols <= WINDOW_COLS_RST;
      cfg.window_rows <= WINDOW_ROWS_RST;
      cfg.player_col  <= PLAYER_COL_RST;
      cfg.player_row  <= PLAYER_ROW_RST;
      cfg.chunk_cols  <= CHUNK_COLS_RST;
      cfg.chunk_rows  <= CHUNK_ROWS_RST;
    end else if (cfg_we) begin
      unique case (vcws_reg_t'(cfg_index))
        REG_TILE_SIZE:   cfg.tile_size   <= cfg_data[7:0];
        REG_WINDOW_COLS: cfg.window_cols <= win_sat;
        REG_WINDOW_ROWS: cfg.window_rows <= win_sat;
        REG_PLAYER_COL:  cfg.player_col  <= cfg_data[5:0];
        REG_PLAYER_ROW:  cfg.player_row  <= cfg_data[5:0];
        REG_CHUNK_COLS:  cfg.chunk_cols  <= chunk_sat;
        REG_CHUNK_ROWS:  cfg.chunk_rows  <= chunk_sat;
        default: begin
        end
      endcase
    end
  end

  vcws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  vcws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  vcws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .rect_valid (rect_valid),
    .rect_stall (rect_stall),
    .rect       (rect)
  );

endmodule

`default_nettype wire
